// ===== rtl/scbd_pkg.sv =====
`default_nettype none
package scbd_pkg;

  typedef logic signed [19:0] coord_t;
  typedef logic signed [39:0] addr_t;

  typedef struct packed {
    logic   valid;
    coord_t x;
    coord_t y;
    coord_t cols;
    coord_t rows;
  } draw_req_t;

  typedef enum logic [2:0] {
    CMD_RC,
    CMD_RF,
    CMD_VL,
    CMD_HL,
    CMD_SZ
  } cmd_e;

  typedef enum logic [3:0] {
    C_IDLE,
    C_POP,
    C_POP_WAIT,
    C_EXEC,
    C_DRAW,
    C_DRAW_WAIT,
    C_PIX_MUL,
    C_PIX_RD,
    C_PIX_OUT
  } ctrl_state_e;

  typedef enum logic [2:0] {
    E_IDLE,
    E_CLEAR,
    E_MUL,
    E_LEN,
    E_ROW,
    E_CHK,
    E_PIX
  } eng_state_e;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_V     = 8'h76;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_L     = 8'h6c;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_Z     = 8'h7a;

  localparam logic [15:0] WIDTH_RESET  = 16'd320;
  localparam logic [15:0] HEIGHT_RESET = 16'd200;

endpackage
`default_nettype wire

// ===== rtl/scbd_ram.sv =====
`default_nettype none
module scbd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
`default_nettype wire

// ===== rtl/scbd_draw.sv =====
`default_nettype none
module scbd_draw #(
  parameter int BITMAP_BITS = 262144,
  localparam int AB = $clog2(BITMAP_BITS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  scbd_pkg::draw_req_t req_i,
  input  logic [15:0]         frame_width_i,
  input  logic [AB-1:0]       rd_addr_i,
  output logic                rd_data_o,
  output logic                busy_o
);
  import scbd_pkg::*;

  localparam addr_t BITS_A = addr_t'(BITMAP_BITS);
  localparam logic [AB-1:0] LAST = AB'(BITMAP_BITS - 1);

  eng_state_e state_q, state_d;
  coord_t x_q, y_q, cols_q, rows_q;
  logic signed [16:0] w_q;
  addr_t start_q, len_q, hi_q;
  logic [16:0] rows_left_q;
  logic [AB-1:0] cur_q, end_q;

  logic signed [36:0] yw, rw;
  addr_t w_ext, start_next;
  logic req_ok, wide, last_row;
  logic ram_we, ram_wd;
  logic [AB-1:0] ram_addr;

  assign yw = y_q * w_q;
  assign rw = (rows_q - coord_t'(1)) * w_q;
  assign w_ext = addr_t'(w_q);
  assign start_next = start_q + w_ext;
  assign req_ok = req_i.valid && (req_i.cols > 0) && (req_i.rows > 0);
  assign wide = cols_q >= coord_t'(w_q);
  assign last_row = rows_left_q == 17'd1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      E_IDLE:  if (req_ok) state_d = E_MUL;
      E_CLEAR: if (cur_q == LAST) state_d = E_IDLE;
      E_MUL:   state_d = E_LEN;
      E_LEN:   state_d = E_ROW;
      E_ROW:   state_d = E_CHK;
      E_CHK: begin
        if (start_q >= BITS_A) begin
          state_d = E_IDLE;
        end else if (hi_q < 0) begin
          state_d = last_row ? E_IDLE : E_ROW;
        end else begin
          state_d = E_PIX;
        end
      end
      E_PIX: begin
        if (cur_q == end_q) state_d = last_row ? E_IDLE : E_ROW;
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_comb begin
    busy_o   = state_q != E_IDLE;
    ram_we   = (state_q == E_CLEAR) || (state_q == E_PIX);
    ram_wd   = state_q == E_PIX;
    ram_addr = ram_we ? cur_q : rd_addr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= E_CLEAR;
      cur_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        E_CLEAR: cur_q <= cur_q + AB'(1);
        E_CHK: begin
          if (start_q < 0) cur_q <= '0;
          else cur_q <= start_q[AB-1:0];
        end
        E_PIX: cur_q <= cur_q + AB'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      E_IDLE: begin
        x_q    <= req_i.x;
        y_q    <= req_i.y;
        cols_q <= req_i.cols;
        rows_q <= req_i.rows;
        w_q    <= $signed({1'b0, frame_width_i});
      end
      E_MUL: start_q <= addr_t'(yw) + addr_t'(x_q);
      E_LEN: begin
        if (wide) begin
          len_q       <= addr_t'(rw) + addr_t'(cols_q) - addr_t'(1);
          rows_left_q <= 17'd1;
        end else begin
          len_q       <= addr_t'(cols_q) - addr_t'(1);
          rows_left_q <= rows_q[16:0];
        end
      end
      E_ROW: hi_q <= start_q + len_q;
      E_CHK: begin
        if (hi_q >= BITS_A) end_q <= LAST;
        else end_q <= hi_q[AB-1:0];
        if (start_q < BITS_A && hi_q < 0) begin
          start_q     <= start_next;
          rows_left_q <= rows_left_q - 17'd1;
        end
      end
      E_PIX: begin
        if (cur_q == end_q) begin
          start_q     <= start_next;
          rows_left_q <= rows_left_q - 17'd1;
        end
      end
      default: ;
    endcase
  end

  scbd_ram #(.WIDTH(1), .DEPTH(BITMAP_BITS)) u_bitmap (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wd),
    .rdata_o(rd_data_o)
  );

endmodule
`default_nettype wire

// ===== rtl/scbd_ctrl.sv =====
`default_nettype none
module scbd_ctrl #(
  parameter int BITMAP_BITS = 262144,
  parameter int STACK_DEPTH = 32,
  parameter int WORD_LIMIT  = 32,
  localparam int AB = $clog2(BITMAP_BITS)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                func_i,
  input  logic [7:0]          char_byte_i,
  input  logic [15:0]         read_x_i,
  input  logic [15:0]         read_y_i,
  input  logic                eng_busy_i,
  input  logic                rd_data_i,
  output logic                busy_o,
  output scbd_pkg::draw_req_t req_o,
  output logic [15:0]         frame_width_o,
  output logic [AB-1:0]       rd_addr_o,
  output logic                valid_o,
  output logic                pixel_o
);
  import scbd_pkg::*;

  localparam int SAW = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int LW  = $clog2(WORD_LIMIT);

  ctrl_state_e state_q, state_d;
  cmd_e cmd_q, cmd_d;
  logic [1:0] k_q, jc_q;
  logic signed [16:0] popv_q [4];
  logic [CW-1:0] count_q;
  logic [LW-1:0] wlen_q;
  logic [7:0] wa_q, wb_q;
  logic [15:0] wnum_q, fw_q, fh_q, rx_q, ry_q;
  logic dend_q;
  logic [32:0] pos_q;
  logic inr_q, valid_q, pixel_q;

  logic acc, sep, digit_c, digit_a, cmd_hit, stk_we, last_pop, last_job;
  logic [SAW-1:0] stk_addr;
  logic [15:0] stk_rd;
  logic [19:0] nv;
  logic [1:0] npop_m1;
  logic [CW-1:0] cnt_m1;

  assign busy_o  = (state_q != C_IDLE) || eng_busy_i;
  assign acc     = start_i && !busy_o;
  assign sep     = (char_byte_i == CH_SPACE) || (char_byte_i == CH_NL);
  assign digit_c = (char_byte_i >= CH_0) && (char_byte_i <= CH_9);
  assign digit_a = (wa_q >= CH_0) && (wa_q <= CH_9);
  assign nv      = {4'b0, wnum_q} * 20'd10 + {12'b0, char_byte_i - CH_0};
  assign cnt_m1  = count_q - CW'(1);
  assign stk_we  = acc && !func_i && sep && (wlen_q != '0) && digit_a
                   && (count_q < CW'(STACK_DEPTH));
  assign stk_addr = stk_we ? count_q[SAW-1:0] : cnt_m1[SAW-1:0];

  always_comb begin
    cmd_hit = 1'b0;
    cmd_d   = CMD_SZ;
    if (wlen_q == LW'(2) && !digit_a) begin
      if (wa_q == CH_R && wb_q == CH_C) begin
        cmd_hit = 1'b1;
        cmd_d   = CMD_RC;
      end else if (wa_q == CH_R && wb_q == CH_F) begin
        cmd_hit = 1'b1;
        cmd_d   = CMD_RF;
      end else if (wa_q == CH_V && wb_q == CH_L) begin
        cmd_hit = 1'b1;
        cmd_d   = CMD_VL;
      end else if (wa_q == CH_H && wb_q == CH_L) begin
        cmd_hit = 1'b1;
        cmd_d   = CMD_HL;
      end else if (wa_q == CH_S && wb_q == CH_Z) begin
        cmd_hit = 1'b1;
        cmd_d   = CMD_SZ;
      end
    end
  end

  always_comb begin
    unique case (cmd_q)
      CMD_RC, CMD_RF: npop_m1 = 2'd3;
      CMD_VL, CMD_HL: npop_m1 = 2'd2;
      default:        npop_m1 = 2'd1;
    endcase
  end
  assign last_pop = k_q == npop_m1;
  assign last_job = (cmd_q != CMD_RC) || (jc_q == 2'd3);

  // draw job for the current command and job index
  always_comb begin
    coord_t p0, p1, p2, p3;
    p0 = coord_t'(popv_q[0]);
    p1 = coord_t'(popv_q[1]);
    p2 = coord_t'(popv_q[2]);
    p3 = coord_t'(popv_q[3]);
    req_o = '0;
    unique case (cmd_q)
      CMD_RC: begin
        req_o.x    = p3;
        req_o.y    = p2;
        req_o.cols = coord_t'(1);
        req_o.rows = p0;
        case (jc_q)
          2'd1: begin
            req_o.cols = p1;
            req_o.rows = coord_t'(1);
          end
          2'd2: begin
            req_o.y    = p2 + p0 - coord_t'(1);
            req_o.cols = p1;
            req_o.rows = coord_t'(1);
          end
          2'd3: req_o.x = p3 + p1 - coord_t'(1);
          default: ;
        endcase
      end
      CMD_RF: begin
        req_o.x    = p3;
        req_o.y    = p2;
        req_o.cols = p1;
        req_o.rows = p0;
      end
      CMD_VL: begin
        req_o.x    = p2;
        req_o.y    = p1;
        req_o.cols = coord_t'(1);
        req_o.rows = p0;
      end
      CMD_HL: begin
        req_o.x    = p2;
        req_o.y    = p1;
        req_o.cols = p0;
        req_o.rows = coord_t'(1);
      end
      default: ;
    endcase
    req_o.valid = state_q == C_DRAW;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE: begin
        if (acc) begin
          if (func_i) state_d = C_PIX_MUL;
          else if (sep && cmd_hit) state_d = C_POP;
        end
      end
      C_POP: begin
        if (count_q != '0) state_d = C_POP_WAIT;
        else if (last_pop) state_d = C_EXEC;
      end
      C_POP_WAIT:  state_d = last_pop ? C_EXEC : C_POP;
      C_EXEC:      state_d = (cmd_q == CMD_SZ) ? C_IDLE : C_DRAW;
      C_DRAW:      state_d = C_DRAW_WAIT;
      C_DRAW_WAIT: begin
        if (!eng_busy_i) state_d = last_job ? C_IDLE : C_DRAW;
      end
      C_PIX_MUL:   state_d = C_PIX_RD;
      C_PIX_RD:    state_d = C_PIX_OUT;
      C_PIX_OUT:   state_d = C_IDLE;
      default:     state_d = C_IDLE;
    endcase
  end

  always_comb begin
    rd_addr_o     = pos_q[AB-1:0];
    frame_width_o = fw_q;
    valid_o       = valid_q;
    pixel_o       = pixel_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      cmd_q   <= CMD_SZ;
      k_q     <= '0;
      jc_q    <= '0;
      count_q <= '0;
      wlen_q  <= '0;
      wa_q    <= '0;
      wb_q    <= '0;
      wnum_q  <= '0;
      dend_q  <= 1'b0;
      fw_q    <= WIDTH_RESET;
      fh_q    <= HEIGHT_RESET;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= state_q == C_PIX_OUT;
      unique case (state_q)
        C_IDLE: begin
          k_q  <= '0;
          jc_q <= '0;
          if (acc && !func_i) begin
            if (sep) begin
              wlen_q <= '0;
              wnum_q <= '0;
              dend_q <= 1'b0;
              cmd_q  <= cmd_d;
              if (stk_we) count_q <= count_q + CW'(1);
            end else if (wlen_q < LW'(WORD_LIMIT - 1)) begin
              if (wlen_q == '0) wa_q <= char_byte_i;
              if (wlen_q == LW'(1)) wb_q <= char_byte_i;
              if (!dend_q && digit_c) wnum_q <= (nv > 20'd65535) ? 16'hffff : nv[15:0];
              else dend_q <= 1'b1;
              wlen_q <= wlen_q + LW'(1);
            end
          end
        end
        C_POP: begin
          if (count_q != '0) begin
            count_q <= cnt_m1;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        C_POP_WAIT: k_q <= k_q + 2'd1;
        C_EXEC: begin
          if (cmd_q == CMD_SZ) begin
            fw_q <= popv_q[1][15:0];
            fh_q <= popv_q[0][15:0];
          end
        end
        C_DRAW_WAIT: if (!eng_busy_i) jc_q <= jc_q + 2'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE: begin
        rx_q <= read_x_i;
        ry_q <= read_y_i;
      end
      C_POP:      if (count_q == '0) popv_q[k_q] <= -17'sd1;
      C_POP_WAIT: popv_q[k_q] <= $signed({1'b0, stk_rd});
      C_PIX_MUL:  pos_q <= {1'b0, 32'(ry_q) * 32'(fw_q)} + {17'b0, rx_q};
      C_PIX_RD:   inr_q <= pos_q < 33'(BITMAP_BITS);
      C_PIX_OUT:  pixel_q <= inr_q & rd_data_i;
      default: ;
    endcase
  end

  scbd_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .addr_i (stk_addr),
    .wdata_i(wnum_q),
    .rdata_o(stk_rd)
  );

endmodule
`default_nettype wire

// ===== rtl/stack_command_bitmap_drawer_core.sv =====
// channel    signals                                       handshake
// request    start_i, func_i, char_byte_i, read_x_i/_y_i   start_i high while busy_o low
// result     valid_o, pixel_o                              one-cycle strobe on valid_o
//
// a command byte is taken while idle, and a finished command word then pops its operands from the stack
// draws write one pixel per cycle through the single bitmap port, with the E_ROW and E_CHK states between rows
// a pixel read passes through C_PIX_MUL, C_PIX_RD and C_PIX_OUT; valid_o follows in the cycle after C_PIX_OUT
// after reset the bitmap is cleared one bit per cycle, with busy_o high until every bit is clear
// the result cannot be stalled
`default_nettype none
module stack_command_bitmap_drawer_core #(
  parameter int BITMAP_BITS = 262144,
  parameter int STACK_DEPTH = 32,
  parameter int WORD_LIMIT  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        func_i,
  input  logic [7:0]  char_byte_i,
  input  logic [15:0] read_x_i,
  input  logic [15:0] read_y_i,
  output logic        valid_o,
  output logic        pixel_o
);
  import scbd_pkg::*;

  localparam int AB = $clog2(BITMAP_BITS);

  draw_req_t req;
  logic [15:0] frame_width;
  logic [AB-1:0] rd_addr;
  logic rd_data, eng_busy;

  scbd_ctrl #(
    .BITMAP_BITS(BITMAP_BITS),
    .STACK_DEPTH(STACK_DEPTH),
    .WORD_LIMIT (WORD_LIMIT)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .func_i       (func_i),
    .char_byte_i  (char_byte_i),
    .read_x_i     (read_x_i),
    .read_y_i     (read_y_i),
    .eng_busy_i   (eng_busy),
    .rd_data_i    (rd_data),
    .busy_o       (busy_o),
    .req_o        (req),
    .frame_width_o(frame_width),
    .rd_addr_o    (rd_addr),
    .valid_o      (valid_o),
    .pixel_o      (pixel_o)
  );

  scbd_draw #(.BITMAP_BITS(BITMAP_BITS)) u_draw (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req),
    .frame_width_i(frame_width),
    .rd_addr_i    (rd_addr),
    .rd_data_o    (rd_data),
    .busy_o       (eng_busy)
  );

endmodule
`default_nettype wire

// ===== dv/scbd_checker.sv =====
module scbd_checker
  import scbd_pkg::*;
#(
  parameter int BITMAP_BITS = 262144,
  parameter int STACK_DEPTH = 32,
  parameter int WORD_LIMIT  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        busy_o,
  input  logic        func_i,
  input  logic [7:0]  char_byte_i,
  input  logic [15:0] read_x_i,
  input  logic [15:0] read_y_i,
  input  logic        valid_o,
  input  logic        pixel_o,
  output int          errors_o,
  output int          pending_o
);

  bit          bitmap_q [BITMAP_BITS];
  logic [15:0] stack_q [STACK_DEPTH];
  int          depth_q;
  int          word_len_q;
  logic [7:0]  first_ch_q;
  logic [7:0]  second_ch_q;
  int          number_q;
  bit          digits_done_q;
  logic [15:0] width_q;
  logic [15:0] height_q;
  bit          expected_pixels [$];

  assign pending_o = expected_pixels.size();

  function automatic void push_operand(int v);
    if (depth_q >= STACK_DEPTH) return;
    stack_q[depth_q] = v[15:0];
    depth_q++;
  endfunction

  function automatic longint pop_operand();
    if (depth_q == 0) return -1;
    depth_q--;
    return longint'(stack_q[depth_q]);
  endfunction

  function automatic void set_span(longint lo, longint hi);
    if (lo < 0) lo = 0;
    if (hi > BITMAP_BITS - 1) hi = BITMAP_BITS - 1;
    for (longint a = lo; a <= hi; a++) bitmap_q[a] = 1'b1;
  endfunction

  function automatic void paint_block(longint x, longint y, longint cols, longint rows);
    longint w;
    longint s;
    w = longint'(width_q);
    if (cols <= 0 || rows <= 0) return;
    if (cols >= w) begin
      set_span(y * w + x, (y + rows - 1) * w + x + cols - 1);
      return;
    end
    for (longint r = 0; r < rows; r++) begin
      s = (y + r) * w + x;
      if (s >= BITMAP_BITS) break;
      if (s + cols - 1 >= 0) set_span(s, s + cols - 1);
    end
  endfunction

  function automatic void finish_word();
    longint a, b, c, d;
    int n;
    n = word_len_q;
    word_len_q = 0;
    digits_done_q = 0;
    if (n == 0) begin
      number_q = 0;
      return;
    end
    if (first_ch_q >= CH_0 && first_ch_q <= CH_9) begin
      push_operand(number_q);
      number_q = 0;
      return;
    end
    number_q = 0;
    if (n != 2) return;
    if (first_ch_q == CH_R && (second_ch_q == CH_C || second_ch_q == CH_F)) begin
      d = pop_operand(); c = pop_operand(); b = pop_operand(); a = pop_operand();
      if (second_ch_q == CH_C) begin
        paint_block(a, b, 1, d);
        paint_block(a, b, c, 1);
        paint_block(a, b + d - 1, c, 1);
        paint_block(a + c - 1, b, 1, d);
      end else begin
        paint_block(a, b, c, d);
      end
    end else if ((first_ch_q == CH_V || first_ch_q == CH_H) && second_ch_q == CH_L) begin
      c = pop_operand(); b = pop_operand(); a = pop_operand();
      if (first_ch_q == CH_V) paint_block(a, b, 1, c);
      else paint_block(a, b, c, 1);
    end else if (first_ch_q == CH_S && second_ch_q == CH_Z) begin
      d = pop_operand(); c = pop_operand();
      width_q  = c[15:0];
      height_q = d[15:0];
    end
  endfunction

  function automatic void take_byte(logic [7:0] ch);
    int v;
    if (ch == CH_SPACE || ch == CH_NL) begin
      finish_word();
      return;
    end
    if (word_len_q >= WORD_LIMIT - 1) return;
    if (word_len_q == 0) first_ch_q = ch;
    if (word_len_q == 1) second_ch_q = ch;
    if (!digits_done_q && ch >= CH_0 && ch <= CH_9) begin
      v = number_q * 10 + int'(ch - CH_0);
      number_q = (v > 65535) ? 65535 : v;
    end else begin
      digits_done_q = 1;
    end
    word_len_q++;
  endfunction

  function automatic bit read_pixel(logic [15:0] x, logic [15:0] y);
    longint unsigned p;
    p = longint'(y) * longint'(width_q) + longint'(x);
    return (p < BITMAP_BITS) ? bitmap_q[p] : 1'b0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    bit want;
    if (!rst_ni) begin
      foreach (bitmap_q[i]) bitmap_q[i] = 1'b0;
      depth_q = 0;
      word_len_q = 0;
      first_ch_q = '0;
      second_ch_q = '0;
      number_q = 0;
      digits_done_q = 0;
      width_q = WIDTH_RESET;
      height_q = HEIGHT_RESET;
      errors_o = 0;
      expected_pixels.delete();
    end else begin
      if (valid_o) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t pixel result with no read pending: actual %0b", $time, pixel_o);
          errors_o++;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_o !== want) begin
            $display("%0t pixel mismatch: expected %0b actual %0b", $time, want, pixel_o);
            errors_o++;
          end
        end
      end
      if (start_i && !busy_o) begin
        if (func_i) expected_pixels.push_back(read_pixel(read_x_i, read_y_i));
        else take_byte(char_byte_i);
      end
    end
  end

endmodule

// ===== dv/tb.sv =====
module tb;
  import scbd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start_i = 0;
  logic        busy_o;
  logic        func_i = 0;
  logic [7:0]  char_byte_i = '0;
  logic [15:0] read_x_i = '0;
  logic [15:0] read_y_i = '0;
  logic        valid_o;
  logic        pixel_o;
  int          errors;
  int          pending;
  int          sent;
  int          quiet_left;
  int          idle_cycles;

  stack_command_bitmap_drawer_core dut (.*);

  scbd_checker chk (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .char_byte_i, .read_x_i, .read_y_i,
    .valid_o, .pixel_o, .errors_o(errors), .pending_o(pending)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_item(bit f, logic [7:0] ch, logic [15:0] x, logic [15:0] y);
    int gap;
    if (quiet_left > 0) begin
      quiet_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 14);
      if ($urandom_range(0, 40) == 0) quiet_left = $urandom_range(20, 60);
    end
    if (gap > 0) begin
      start_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    start_i     <= 1;
    func_i      <= f;
    char_byte_i <= ch;
    read_x_i    <= x;
    read_y_i    <= y;
    forever begin
      @(negedge clk_i);
      if (!busy_o) break;
    end
    @(posedge clk_i);
    sent++;
  endtask

  task automatic send_char(logic [7:0] ch);
    send_item(0, ch, 16'($urandom), 16'($urandom));
  endtask

  task automatic send_word(string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
    send_char($urandom_range(0, 1) ? CH_SPACE : CH_NL);
  endtask

  task automatic read_at(logic [15:0] x, logic [15:0] y);
    send_item(1, 8'($urandom), x, y);
  endtask

  task automatic send_num(int v);
    send_word($sformatf("%0d", v));
  endtask

  function automatic int small_val();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 400) : $urandom_range(0, 40);
  endfunction

  initial begin
    string cmds [4] = '{"rc", "rf", "vl", "hl"};
    string s;
    int r;
    sent = 0;
    quiet_left = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed
    read_at(0, 0);
    read_at(16'hffff, 16'hffff);
    send_word("hl");
    send_word("sz");
    read_at(3, 0);
    send_word("320 200 sz");
    send_char(CH_SPACE);
    send_char(CH_NL);
    send_word("99999");
    send_word("12ab");
    send_item(0, 8'h00, 0, 0);
    send_item(0, 8'hff, 16'hffff, 16'hffff);
    send_char(CH_SPACE);
    send_word("3 4 5 vl");
    send_word("3 4 5 hl");
    send_word("2 2 6 4 rc");
    send_word("10 10 3 3 rf");
    send_word("5 0 3 65535 rf");
    send_word("tx rcx r");
    s = "";
    repeat (40) s = {s, "a"};
    send_word({"rf", s});
    send_word({"7", s});
    read_at(5, 6);
    read_at(5, 300);
    send_word("8 8 sz 1 1 20 2 rf");
    read_at(3, 2);
    send_word("0 5 sz 2 0 4 1 rf");
    read_at(4, 0);
    repeat (34) send_word("1");
    send_word("65535 65535 sz");
    read_at(1, 0);
    read_at(0, 1);
    send_word("320 200 sz");

    // random
    while (sent < 1900) begin
      r = $urandom_range(0, 99);
      if (sent > 900 && sent < 930) begin
        start_i <= 0;
        while (pending != 0) @(posedge clk_i);
      end
      if (r < 25) begin
        s = $sformatf("%0d", ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99999) : small_val());
        if ($urandom_range(0, 7) == 0) s = {s, "q1"};
        send_word(s);
      end else if (r < 45) begin
        s = cmds[$urandom_range(0, 3)];
        if ($urandom_range(0, 9) != 0) begin
          send_num(small_val());
          send_num(small_val());
          send_num(small_val());
          if (s[0] == "r") send_num(small_val());
        end
        send_word(s);
      end else if (r < 72) begin
        if ($urandom_range(0, 7) == 0) read_at(16'($urandom), 16'($urandom));
        else read_at(16'($urandom_range(0, 60)), 16'($urandom_range(0, 60)));
      end else if (r < 77) begin
        case ($urandom_range(0, 9))
          0: send_num(0);
          1: send_num(65535);
          default: send_num($urandom_range(1, 400));
        endcase
        send_num($urandom_range(0, 65535));
        send_word("sz");
      end else if (r < 90) begin
        repeat ($urandom_range(1, 6)) send_char(8'($urandom));
        send_char($urandom_range(0, 1) ? CH_SPACE : CH_NL);
      end else begin
        case ($urandom_range(0, 3))
          0: send_word({cmds[$urandom_range(0, 3)], "x"});
          1: send_word("s");
          2: send_word("tx");
          default: begin
            s = "";
            repeat ($urandom_range(28, 36)) s = {s, "9"};
            send_word(s);
          end
        endcase
      end
    end

    // whole-store fill and a few reads
    send_word("320 200 sz 0 0 65535 65535 rf");
    read_at(0, 0);
    read_at(319, 818);
    read_at(0, 820);
    start_i <= 0;

    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
